[design/plti_pkg.sv]
// ----------------------------------------------------------------------------
// plti_pkg - shared types and constants of the table interpolator
// Table size, field widths, the search token that walks the cell row,
// the divider request and the state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package plti_pkg;

    // Table geometry and field widths
    localparam int TABLE_POINTS = 16;
    localparam int VAL_W        = 16;
    localparam int IDX_W        = 4;
    localparam int IN_DATA_W    = 56;
    localparam int DIV_CNT_W    = 3;
    localparam int DIV_STEPS    = 2;

    // Item kinds carried in tuser
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_CONVERT = 1'b1;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             has_prev;
        logic             found;
        logic             exact;
        logic [VAL_W-1:0] sample;
        logic [VAL_W-1:0] prev_v;
        logic [VAL_W-1:0] prev_a;
        logic [VAL_W-1:0] first_v;
        logic [VAL_W-1:0] first_a;
        logic [VAL_W-1:0] seg_v0;
        logic [VAL_W-1:0] seg_v1;
        logic [VAL_W-1:0] seg_a0;
        logic [VAL_W-1:0] seg_a1;
    } plti_token_t;

    // Segment handed to the divider
    typedef struct packed {
        logic [VAL_W-1:0] v0;
        logic [VAL_W-1:0] v1;
        logic [VAL_W-1:0] a0;
        logic [VAL_W-1:0] a1;
        logic [VAL_W-1:0] sample;
    } plti_div_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV,
        ST_OUT
    } plti_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_MUL,
        DV_RUN,
        DV_DONE
    } plti_div_state_t;

endpackage

`default_nettype wire

[design/plti_cell.sv]
// ----------------------------------------------------------------------------
// plti_cell - one table point of the interpolator row
// Holds one (voltage, air mass) point and tests the segment that ends at
// this point against the token passing through, one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_cell
    import plti_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [VAL_W-1:0]  wr_voltage,
    input  wire logic [VAL_W-1:0]  wr_airmass,
    input  wire plti_token_t       tok_in,
    output plti_token_t            tok_out
);

    logic [VAL_W-1:0] volt_reg;
    logic [VAL_W-1:0] air_reg;
    logic             tok_valid_reg;
    plti_token_t      tok_reg;
    plti_token_t      tok_next;

    // Store the point on a load beat
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            volt_reg <= wr_voltage;
            air_reg  <= wr_airmass;
        end
    end

    // Test the segment from the previous point to this one
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.has_prev)
        begin
            if (!tok_in.found)
            begin
                if (tok_in.prev_v == tok_in.sample)
                begin
                    tok_next.found  = 1'b1;
                    tok_next.exact  = 1'b1;
                    tok_next.seg_a0 = tok_in.prev_a;
                end
                else if (tok_in.prev_v <= tok_in.sample && tok_in.sample <= volt_reg)
                begin
                    tok_next.found  = 1'b1;
                    tok_next.seg_v0 = tok_in.prev_v;
                    tok_next.seg_v1 = volt_reg;
                    tok_next.seg_a0 = tok_in.prev_a;
                    tok_next.seg_a1 = air_reg;
                end
            end
        end
        else
        begin
            // first point of the table
            tok_next.has_prev = 1'b1;
            tok_next.first_v  = volt_reg;
            tok_next.first_a  = air_reg;
        end
        tok_next.prev_v = volt_reg;
        tok_next.prev_a = air_reg;
    end

    // Advance the token valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_next.valid;
        end
    end

    // Advance the token payload
    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    // Merge the valid bit back into the token
    always_comb
    begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

`default_nettype wire

[design/plti_div.sv]
// ----------------------------------------------------------------------------
// plti_div - segment interpolation unit
// Forms |da| * ds in one registered multiply, then divides by the segment
// width two quotient bits per cycle and applies the floor for falling
// segments.
// ----------------------------------------------------------------------------
`default_nettype none

module plti_div
    import plti_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire plti_div_req_t     req,
    output logic                   done,
    output logic [VAL_W-1:0]       result
);

    plti_div_state_t        state_reg;
    plti_div_state_t        state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;

    logic                   neg_reg;
    logic                   neg_next;
    logic [VAL_W-1:0]       mag_da_reg;
    logic [VAL_W-1:0]       mag_da_next;
    logic [VAL_W-1:0]       mag_ds_reg;
    logic [VAL_W-1:0]       mag_ds_next;
    logic [VAL_W-1:0]       den_reg;
    logic [VAL_W-1:0]       den_next;
    logic [VAL_W-1:0]       base_reg;
    logic [VAL_W-1:0]       base_next;
    logic [VAL_W:0]         rem_reg;
    logic [VAL_W:0]         rem_next;
    logic [VAL_W-1:0]       quo_reg;
    logic [VAL_W-1:0]       quo_next;

    logic [2*VAL_W-1:0]     product;
    logic [VAL_W:0]         rem_step;
    logic [VAL_W-1:0]       quo_step;
    logic [VAL_W:0]         sum_up;
    logic [VAL_W:0]         sum_down;

    assign product = mag_da_reg * mag_ds_reg;

    // Restoring divide, two quotient bits per cycle
    always_comb
    begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            rem_step = {rem_step[VAL_W-1:0], quo_step[VAL_W-1]};
            if (rem_step >= {1'b0, den_reg})
            begin
                rem_step = rem_step - {1'b0, den_reg};
                quo_step = {quo_step[VAL_W-2:0], 1'b1};
            end
            else
            begin
                quo_step = {quo_step[VAL_W-2:0], 1'b0};
            end
        end
    end

    // Rising segment adds the quotient, falling one subtracts its ceiling
    assign sum_up   = {1'b0, base_reg} + {1'b0, quo_reg};
    assign sum_down = {1'b0, base_reg} - {1'b0, quo_reg}
                      - {{VAL_W{1'b0}}, (rem_reg != '0)};

    // Sequence the multiply and divide
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        mag_da_next = mag_da_reg;
        mag_ds_next = mag_ds_reg;
        den_next    = den_reg;
        base_next   = base_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        done        = 1'b0;
        result      = neg_reg ? sum_down[VAL_W-1:0] : sum_up[VAL_W-1:0];
        case (state_reg)
            DV_IDLE:
            begin
                if (start)
                begin
                    neg_next    = (req.a1 < req.a0);
                    mag_da_next = (req.a1 < req.a0) ? (req.a0 - req.a1) : (req.a1 - req.a0);
                    mag_ds_next = req.sample - req.v0;
                    den_next    = req.v1 - req.v0;
                    base_next   = req.a0;
                    state_next  = DV_MUL;
                end
            end
            DV_MUL:
            begin
                // high half is below the divisor since the quotient fits 16 bits
                rem_next   = {1'b0, product[2*VAL_W-1:VAL_W]};
                quo_next   = product[VAL_W-1:0];
                cnt_next   = '0;
                state_next = DV_RUN;
            end
            DV_RUN:
            begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '1)
                begin
                    state_next = DV_DONE;
                end
            end
            DV_DONE:
            begin
                done       = 1'b1;
                state_next = DV_IDLE;
            end
            default:
            begin
                state_next = DV_IDLE;
            end
        endcase
    end

    // Hold the control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Hold the operands
    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        mag_da_reg <= mag_da_next;
        mag_ds_reg <= mag_ds_next;
        den_reg    <= den_next;
        base_reg   <= base_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
    end

endmodule

`default_nettype wire

[design/piecewise_linear_table_interpolator_core.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_core - calibration table interpolator
// Loads (voltage, air mass) points into a row of cells and converts sample
// voltages to air mass by clamping or floor-exact linear interpolation.
// ----------------------------------------------------------------------------
//  channel | direction | signals                  | contents
//  s_*     | in        | tvalid tready tdata tuser| load point or sample to convert
//  m_*     | out       | tvalid tready tdata      | air mass, one per convert beat
//
//  A load beat writes its cell; the block is free again at once.
//  A convert beat walks the 16-cell row one cell per cycle; a clamped,
//  exact or unbracketed answer then goes straight to the output step,
//  while an interpolated segment first passes through start, multiply,
//  radix-4 divide and finish before the output step.
//  One item is in work at a time; s_tready drops until it reaches the output
//  register, longer while m_tready holds off a waiting result.
//  Reset clears all control state; table contents stay unknown.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_table_interpolator_core
    import plti_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // point_index[3:0], point_voltage[19:4], point_airmass[35:20],
    // sample_voltage[51:36], zero fill [55:52]
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op[0]
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // air_mass[15:0]
    output logic [VAL_W-1:0]           m_tdata
);

    plti_state_t       state_reg;
    plti_state_t       state_next;
    logic [VAL_W-1:0]  res_reg;
    logic [VAL_W-1:0]  res_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [VAL_W-1:0]  m_data_reg;
    logic [VAL_W-1:0]  m_data_next;

    logic              in_beat;
    logic [IDX_W-1:0]  in_index;
    logic [VAL_W-1:0]  in_voltage;
    logic [VAL_W-1:0]  in_airmass;
    logic [VAL_W-1:0]  in_sample;

    plti_token_t       tok_launch;
    plti_token_t       tok_chain [TABLE_POINTS+1];
    plti_token_t       tok_last;
    plti_div_req_t     div_req;
    logic              div_start;
    logic              div_done;
    logic [VAL_W-1:0]  div_result;

    // Unpack the input beat
    assign in_beat    = s_tvalid && s_tready;
    assign in_index   = s_tdata[IDX_W-1:0];
    assign in_voltage = s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign in_airmass = s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
    assign in_sample  = s_tdata[IDX_W+3*VAL_W-1:IDX_W+2*VAL_W];

    // Launch a search token into the first cell
    always_comb
    begin
        tok_launch        = '0;
        tok_launch.valid  = in_beat && (s_tuser == OP_CONVERT);
        tok_launch.sample = in_sample;
    end

    assign tok_chain[0] = tok_launch;

    // Row of table cells
    for (genvar k = 0; k < TABLE_POINTS; k++)
    begin : g_cell
        plti_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .wr_en      (in_beat && (s_tuser == OP_LOAD) && (int'(in_index) == k)),
            .wr_voltage (in_voltage),
            .wr_airmass (in_airmass),
            .tok_in     (tok_chain[k]),
            .tok_out    (tok_chain[k+1])
        );
    end

    assign tok_last = tok_chain[TABLE_POINTS];

    assign div_req.v0     = tok_last.seg_v0;
    assign div_req.v1     = tok_last.seg_v1;
    assign div_req.a0     = tok_last.seg_a0;
    assign div_req.a1     = tok_last.seg_a1;
    assign div_req.sample = tok_last.sample;

    plti_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .req    (div_req),
        .done   (div_done),
        .result (div_result)
    );

    // Sequence one item and drive the output register
    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        div_start    = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == OP_CONVERT)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (tok_last.valid)
                begin
                    // last point sits in prev_* after the row
                    if (tok_last.sample >= tok_last.prev_v)
                    begin
                        res_next   = tok_last.prev_a;
                        state_next = ST_OUT;
                    end
                    else if (tok_last.sample <= tok_last.first_v)
                    begin
                        res_next   = tok_last.first_a;
                        state_next = ST_OUT;
                    end
                    else if (!tok_last.found)
                    begin
                        res_next   = '0;
                        state_next = ST_OUT;
                    end
                    else if (tok_last.exact)
                    begin
                        res_next   = tok_last.seg_a0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_result;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

[tb/plti_airmass_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plti_airmass_checker - scoreboard for the table interpolator
// Watches both stream channels, keeps a shadow calibration table from the
// load beats, predicts the air mass of every convert beat and compares each
// output beat with the oldest prediction.
// ----------------------------------------------------------------------------

module plti_airmass_checker
    import plti_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    // point_index, point_voltage, point_airmass, sample_voltage, zero fill
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    // air_mass
    input  wire logic [VAL_W-1:0]      m_tdata,
    output int                         mismatch_count,
    output int                         pending_count
);

    localparam int     PV_LSB   = IDX_W;
    localparam int     PA_LSB   = IDX_W + VAL_W;
    localparam int     SV_LSB   = IDX_W + 2 * VAL_W;
    localparam longint MASS_MAX = (longint'(1) << VAL_W) - 1;

    logic [VAL_W-1:0] cal_volt [TABLE_POINTS];
    logic [VAL_W-1:0] cal_mass [TABLE_POINTS];
    logic [VAL_W-1:0] airmass_due [$];
    int               mismatches = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    // Clamp at both ends, exact match on a point, else floor of the lerp
    function automatic logic [VAL_W-1:0] interp_airmass(input logic [VAL_W-1:0] sample);
        longint           num;
        longint           den;
        longint           quo;
        longint           sum;
        logic [VAL_W-1:0] v0;
        logic [VAL_W-1:0] v1;
        logic [VAL_W-1:0] a0;
        logic [VAL_W-1:0] a1;
        if (sample >= cal_volt[TABLE_POINTS-1])
            return cal_mass[TABLE_POINTS-1];
        if (sample <= cal_volt[0])
            return cal_mass[0];
        for (int k = 0; k < TABLE_POINTS - 1; k++)
        begin
            v0 = cal_volt[k];
            v1 = cal_volt[k+1];
            a0 = cal_mass[k];
            a1 = cal_mass[k+1];
            if (v0 == sample)
                return a0;
            if (v0 <= sample && sample <= v1)
            begin
                num = (longint'(a1) - longint'(a0)) * (longint'(sample) - longint'(v0));
                den = longint'(v1) - longint'(v0);
                if (den <= 0)
                    return a0;
                quo = num / den;
                // round toward minus infinity on a falling segment
                if (num < 0 && (num % den) != 0)
                    quo = quo - 1;
                sum = longint'(a0) + quo;
                if (sum < 0)
                    sum = 0;
                else if (sum > MASS_MAX)
                    sum = MASS_MAX;
                return VAL_W'(sum);
            end
        end
        // non-ascending table with no bracketing segment
        return '0;
    endfunction

    always @(posedge clk)
    begin
        logic [VAL_W-1:0] want;
        logic [IDX_W-1:0] idx;
        if (rst_n)
        begin
            // Compare each output beat with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                if (airmass_due.size() == 0)
                    report_mismatch($sformatf("air_mass %0d with no conversion pending",
                                              m_tdata));
                else
                begin
                    want = airmass_due.pop_front();
                    if (m_tdata !== want)
                        report_mismatch($sformatf("air_mass %0d, expected %0d",
                                                  m_tdata, want));
                end
            end

            // Update the shadow table or predict on each input beat
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_LOAD)
                begin
                    idx = s_tdata[IDX_W-1:0];
                    if (int'(idx) < TABLE_POINTS)
                    begin
                        cal_volt[idx] = s_tdata[PV_LSB +: VAL_W];
                        cal_mass[idx] = s_tdata[PA_LSB +: VAL_W];
                    end
                end
                else
                    airmass_due.push_back(interp_airmass(s_tdata[SV_LSB +: VAL_W]));
            end
        end
        mismatch_count <= mismatches;
        pending_count  <= airmass_due.size();
    end

endmodule

[tb/piecewise_linear_table_interpolator_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// piecewise_linear_table_interpolator_core_tb - interpolator testbench
// Loads calibration tables and converts samples: a directed pass over the
// clamps, exact points and broken tables, then random ascending tables with
// samples aimed at points, neighbors and segments, plus stray loads. Both
// sides idle in short bursts and the output side holds off once for long.
// ----------------------------------------------------------------------------

module piecewise_linear_table_interpolator_core_tb;
    import plti_pkg::*;

    localparam int ITEM_TARGET   = 900;
    localparam int CALM_START    = 780;
    localparam int HOLD_AT_CYCLE = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int FILL_W        = IN_DATA_W - IDX_W - 3 * VAL_W;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [VAL_W-1:0]     m_tdata;

    int                   mismatch_count;
    int                   pending_count;
    int                   cycle_count = 0;
    int                   items_sent  = 0;
    bit                   idling_on   = 1'b1;
    int                   stall_left  = 0;
    bit                   hold_done   = 1'b0;

    // table as loaded, used only to aim samples
    logic [VAL_W-1:0]     loaded_volt [TABLE_POINTS];
    logic [VAL_W-1:0]     loaded_mass [TABLE_POINTS];

    piecewise_linear_table_interpolator_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    plti_airmass_checker airmass_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("piecewise_linear_table_interpolator_core_tb: errors");
            $finish;
        end
    end

    // Drive m_tready: one long hold-off, short random stalls, none when calm
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!hold_done && cycle_count >= HOLD_AT_CYCLE)
        begin
            hold_done  <= 1'b1;
            stall_left <= HOLD_CYCLES - 1;
            m_tready   <= 1'b0;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Mostly random words, with the extremes now and then
    function automatic logic [VAL_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       rand_word = '0;
            1:       rand_word = '1;
            default: rand_word = VAL_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offer one beat, maybe after a short gap, and hold it until taken
    task automatic send_item(input logic op, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] pv, input logic [VAL_W-1:0] pa,
                             input logic [VAL_W-1:0] sv);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{FILL_W{1'b0}}, sv, pa, pv, idx};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic load_point(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] v,
                              input logic [VAL_W-1:0] a);
        loaded_volt[idx] = v;
        loaded_mass[idx] = a;
        send_item(OP_LOAD, idx, v, a, rand_word());
    endtask

    task automatic convert(input logic [VAL_W-1:0] sv);
        send_item(OP_CONVERT, IDX_W'($urandom_range(0, TABLE_POINTS - 1)),
                  rand_word(), rand_word(), sv);
    endtask

    // Load a full table with non-descending voltages, dense or wide
    task automatic load_ascending_table();
        int base;
        int step_max;
        int v;
        base     = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4096);
        step_max = ($urandom_range(0, 3) == 0) ? 3 : (65535 - base) / (TABLE_POINTS - 1);
        v        = base;
        for (int i = 0; i < TABLE_POINTS; i++)
        begin
            load_point(IDX_W'(i), VAL_W'(v), rand_word());
            v += $urandom_range(0, step_max);
        end
    endtask

    initial
    begin
        int               pick;
        int               k;
        int               lo;
        int               hi;
        logic [VAL_W-1:0] sv;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full table with rising and falling segments
        for (int i = 0; i < TABLE_POINTS; i++)
            load_point(IDX_W'(i),
                       (i == TABLE_POINTS - 1) ? VAL_W'(65535) : VAL_W'(i * 4000),
                       (i == TABLE_POINTS - 1) ? VAL_W'(65535) :
                       (i % 2) ? VAL_W'(65535 - i * 100) : VAL_W'(i * 300));
        convert(16'd0);         // at the first point
        convert(16'd65535);     // at the last point
        convert(16'd4000);      // exact point
        convert(16'd4001);      // falling segment, floor
        convert(16'd6001);      // falling segment, mid
        convert(16'd62000);     // rising last segment
        convert(16'd1);         // rising first segment

        // Directed: break the order so the sample hits both ends
        load_point(IDX_W'(TABLE_POINTS - 1), 16'd10, 16'd777);
        load_point(IDX_W'(0), 16'd20, 16'd123);
        convert(16'd15);
        convert(16'd5);
        convert(16'd20);

        // Random: fresh tables, stray loads and bursts of aimed conversions
        load_ascending_table();
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= CALM_START)
                idling_on <= 1'b0;
            pick = $urandom_range(0, 9);
            if (pick < 2)
                load_ascending_table();
            else if (pick < 3)
                load_point(IDX_W'($urandom_range(0, TABLE_POINTS - 1)), rand_word(),
                           rand_word());
            else
                repeat ($urandom_range(4, 12))
                begin
                    k = $urandom_range(0, TABLE_POINTS - 2);
                    case ($urandom_range(0, 3))
                        0: sv = VAL_W'($urandom_range(0, 65535));
                        1: sv = loaded_volt[k + $urandom_range(0, 1)];
                        2: sv = ($urandom_range(0, 1) == 1) ? loaded_volt[k] + 1'b1 :
                                                              loaded_volt[k] - 1'b1;
                        default:
                        begin
                            lo = loaded_volt[k];
                            hi = loaded_volt[k+1];
                            sv = (hi > lo) ? VAL_W'(lo + $urandom_range(0, hi - lo)) :
                                             VAL_W'(lo);
                        end
                    endcase
                    convert(sv);
                end
        end
        s_tvalid <= 1'b0;

        // Drain outstanding results, then watch for strays
        do @(posedge clk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("piecewise_linear_table_interpolator_core_tb: clean");
        else
            $display("piecewise_linear_table_interpolator_core_tb: errors");
        $finish;
    end

endmodule
